>>> rtl/isam_pkg.sv
// Shared types for the interval sort-and-merge block.
// Holds the stored interval entry and the comparator result struct.
// No dependencies.
`timescale 1ns / 1ps

package isam_pkg;

    localparam int POINT_W = 32;

    // One stored interval, start in the low half
    typedef struct packed {
        logic signed [POINT_W-1:0] end_pt;
        logic signed [POINT_W-1:0] start_pt;
    } isam_entry_t;

    // Result of the shared compare unit: upper pair and lower pair
    typedef struct packed {
        logic hi_lt;
        logic hi_eq;
        logic lo_lt;
    } isam_cmp_t;

endpackage

>>> rtl/isam_cmp.sv
// Shared signed compare unit of the interval sort-and-merge block.
// Compares two pairs of 32-bit points at once; depends on isam_pkg.
`timescale 1ns / 1ps

module isam_cmp import isam_pkg::*; (
    input  logic signed [POINT_W-1:0] a_hi,
    input  logic signed [POINT_W-1:0] b_hi,
    input  logic signed [POINT_W-1:0] a_lo,
    input  logic signed [POINT_W-1:0] b_lo,
    output isam_cmp_t                 res
);

    always_comb begin
        res.hi_lt = (a_hi < b_hi);
        res.hi_eq = (a_hi == b_hi);
        res.lo_lt = (a_lo < b_lo);
    end

endmodule

>>> rtl/isam_store.sv
// Interval store of the interval sort-and-merge block.
// One write port, one read port with registered read data; depends on isam_pkg.
`timescale 1ns / 1ps

module isam_store import isam_pkg::*; #(
    parameter int   DEPTH  = 64,
    localparam int  ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  isam_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output isam_entry_t       rd_data
);

    isam_entry_t mem [DEPTH];
    isam_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read request
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/interval_sort_and_merge.sv
// Interval sort-and-merge top level: sequencer, output register and assertions.
// Uses isam_pkg, isam_store (interval memory) and isam_cmp (shared comparator).
`timescale 1ns / 1ps

// Usage:
//   Input channel s_*: one closed interval per request, start in s_tdata[31:0],
//   end in s_tdata[63:32], s_tlast marks the last interval of a set.
//   Result channel m_*: one merged interval per request, start in m_tdata[31:0],
//   end in m_tdata[63:32], m_tlast on the last merged interval of the set,
//   m_tuser high on every result of a set in which intervals were dropped.
//   Each interval is inserted into a sorted memory by walking down from the top
//   entry, one entry per cycle through the single comparator; s_tready stays
//   low until the insert ends.
//   An interval arriving while MAX_INTERVALS are stored is dropped and flagged.
//   After the interval marked s_tlast is stored, the merge reads the memory
//   once, one entry per cycle while the output register can take each result.
//   A single output register carries results; while m_tready is low the merge
//   holds at the next result and s_tready stays low until the last result of
//   the set has been loaded into the output register.
//   Reset (aresetn low, synchronous) empties the store and drops any result.
module interval_sort_and_merge import isam_pkg::*; #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] interval_start, [63:32] interval_end
    input  logic        s_tlast,   // final_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] merged_start, [63:32] merged_end
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] dropped_flag
);

    localparam int ADDR_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // take a request
    localparam logic [2:0] ST_INS    = 3'd1;  // compare and shift one entry up
    localparam logic [2:0] ST_PUT    = 3'd2;  // write new interval at entry 0
    localparam logic [2:0] ST_MSTART = 3'd3;  // read entry 0
    localparam logic [2:0] ST_MLOAD  = 3'd4;  // open the first merged interval
    localparam logic [2:0] ST_MSTEP  = 3'd5;  // fold one entry into the merge
    localparam logic [2:0] ST_MLAST  = 3'd6;  // emit the closing interval

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    isam_entry_t       new_reg, new_next;
    logic              fin_reg, fin_next;
    logic signed [POINT_W-1:0] cur_s_reg, cur_s_next;
    logic signed [POINT_W-1:0] cur_e_reg, cur_e_next;

    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_user_reg, out_user_next;

    // store and comparator hookup
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    isam_entry_t       wr_data, rd_data, in_entry;
    logic signed [POINT_W-1:0] a_hi, b_hi, a_lo, b_lo;
    isam_cmp_t         cmp;

    logic              load_out, emit_last, can_load, lex_lt, at_end;

    isam_store #(.DEPTH(MAX_INTERVALS)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    isam_cmp u_cmp (
        .a_hi (a_hi),
        .b_hi (b_hi),
        .a_lo (a_lo),
        .b_lo (b_lo),
        .res  (cmp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_entry.start_pt = s_tdata[31:0];
    assign in_entry.end_pt   = s_tdata[63:32];

    // The comparator serves the insert walk (new against stored, start then
    // end) and the merge (running end against stored start and stored end).
    always_comb begin
        if (state_reg == ST_MSTEP) begin
            a_hi = cur_e_reg;
            b_hi = rd_data.start_pt;
            a_lo = cur_e_reg;
            b_lo = rd_data.end_pt;
        end else begin
            a_hi = new_reg.start_pt;
            b_hi = rd_data.start_pt;
            a_lo = new_reg.end_pt;
            b_lo = rd_data.end_pt;
        end
    end

    assign lex_lt   = cmp.hi_lt | (cmp.hi_eq & cmp.lo_lt);
    assign can_load = !out_valid_reg || m_tready;
    assign at_end   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        new_next   = new_reg;
        fin_next   = fin_reg;
        cur_s_next = cur_s_reg;
        cur_e_next = cur_e_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = new_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        load_out   = 1'b0;
        emit_last  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    new_next = in_entry;
                    fin_next = s_tlast;
                    if (count_reg == CNT_W'(MAX_INTERVALS)) begin
                        // store full: drop the interval
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? ST_MSTART : ST_IDLE;
                    end else if (count_reg == '0) begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = in_entry;
                        count_next = CNT_W'(1);
                        state_next = s_tlast ? ST_MSTART : ST_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(count_reg - CNT_W'(1));
                        pos_next   = ADDR_W'(count_reg);
                        state_next = ST_INS;
                    end
                end
            end
            ST_INS: begin
                wr_en = 1'b1;
                if (lex_lt) begin
                    // shift the stored entry up one place
                    wr_data  = rd_data;
                    pos_next = pos_reg - ADDR_W'(1);
                    if (pos_reg == ADDR_W'(1)) begin
                        state_next = ST_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - ADDR_W'(2);
                    end
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = fin_reg ? ST_MSTART : ST_IDLE;
                end
            end
            ST_PUT: begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = fin_reg ? ST_MSTART : ST_IDLE;
            end
            ST_MSTART: begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = ADDR_W'(1);
                state_next = ST_MLOAD;
            end
            ST_MLOAD: begin
                cur_s_next = rd_data.start_pt;
                cur_e_next = rd_data.end_pt;
                if (count_reg == CNT_W'(1)) begin
                    state_next = ST_MLAST;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_MSTEP;
                end
            end
            ST_MSTEP: begin
                if (!cmp.hi_lt || can_load) begin
                    if (cmp.hi_lt) begin
                        // gap: close the running interval, open a new one
                        load_out   = 1'b1;
                        cur_s_next = rd_data.start_pt;
                        cur_e_next = rd_data.end_pt;
                    end else if (cmp.lo_lt) begin
                        cur_e_next = rd_data.end_pt;
                    end
                    if (at_end) begin
                        state_next = ST_MLAST;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_MLAST: begin
                if (can_load) begin
                    load_out   = 1'b1;
                    emit_last  = 1'b1;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = {cur_e_reg, cur_s_reg};
            out_last_next  = emit_last;
            out_user_next  = ovf_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        new_reg      <= new_next;
        fin_reg      <= fin_next;
        cur_s_reg    <= cur_s_next;
        cur_e_reg    <= cur_e_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // a dropped interval is only possible with a full store
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (count_reg == CNT_W'(MAX_INTERVALS)))
        else $error("overflow flag set with store not full");

    // the merge never runs on an empty store
    a_merge_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MLOAD || state_reg == ST_MSTEP || state_reg == ST_MLAST)
        |-> (count_reg != '0))
        else $error("merge running on empty store");

    // the insert walk stays inside the filled part of the store
    a_ins_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS) |-> (pos_reg != '0 && CNT_W'(pos_reg) <= count_reg))
        else $error("insert position out of range");

    // the set closes by emitting a last result and emptying the store
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MLAST && can_load)
        |=> (out_valid_reg && out_last_reg && count_reg == '0))
        else $error("set did not close with a last result");
`endif

endmodule

>>> dv/tb_interval_sort_and_merge.sv
// Self-checking testbench for interval_sort_and_merge: drives interval sets on s_*,
// predicts the merged intervals in a local sorted store and checks every m_* result.
// Depends on rtl/isam_pkg.sv and rtl/interval_sort_and_merge.sv.
`timescale 1ns / 1ps

module tb_interval_sort_and_merge import isam_pkg::*; ();

    localparam int MAX_SPANS = 64;
    localparam logic [POINT_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [POINT_W-1:0] MOST_POS = 32'h7FFF_FFFF;

    // One merged interval as it should leave the block
    typedef struct packed {
        isam_entry_t span;
        logic        is_last;
        logic        dropped;
    } merged_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // [31:0] interval_start, [63:32] interval_end
    logic        s_tlast  = 1'b0;  // final_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [31:0] merged_start, [63:32] merged_end
    logic        m_tlast;          // run_last
    logic        m_tuser;          // [0] dropped_flag

    // Predictor state: sorted copy of the block's interval store
    isam_entry_t sorted_spans [MAX_SPANS];
    int          span_count  = 0;
    bit          spill_seen  = 1'b0;
    merged_t     expected_merges [$];
    merged_t     oldest_merge;

    bit no_gaps     = 1'b0;
    int error_count = 0;
    int intervals_taken = 0;
    int sets_closed     = 0;
    int sets_spilled    = 0;
    int merges_checked  = 0;

    interval_sort_and_merge #(.MAX_INTERVALS(MAX_SPANS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #10ms;
        $display("%0t: timeout, %0d merged intervals still awaited", $time,
                 expected_merges.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Ascending start, ascending end on a tie, both signed
    function automatic bit precedes(isam_entry_t a, isam_entry_t b);
        return ($signed(a.start_pt) < $signed(b.start_pt)) ||
               (a.start_pt == b.start_pt && $signed(a.end_pt) < $signed(b.end_pt));
    endfunction

    // Append one merged interval to the list of awaited results
    function automatic void queue_merge(isam_entry_t span, bit is_last, bit dropped);
        merged_t entry;
        entry.span    = span;
        entry.is_last = is_last;
        entry.dropped = dropped;
        expected_merges.insert(expected_merges.size(), entry);
    endfunction

    // Insert one accepted interval; on the set's closing request, merge the
    // store and queue the merged intervals, then empty the store.
    function automatic void absorb_interval(isam_entry_t span, bit closes_set);
        int          pos;
        isam_entry_t run;
        if (span_count < MAX_SPANS) begin
            pos = span_count;
            while (pos > 0 && precedes(span, sorted_spans[pos-1])) begin
                sorted_spans[pos] = sorted_spans[pos-1];
                pos--;
            end
            sorted_spans[pos] = span;
            span_count++;
        end else begin
            spill_seen = 1'b1;
        end
        if (!closes_set)
            return;
        run = sorted_spans[0];
        for (int i = 1; i < span_count; i++) begin
            // Touching intervals (start equal to running end) merge as well
            if ($signed(sorted_spans[i].start_pt) <= $signed(run.end_pt)) begin
                if ($signed(sorted_spans[i].end_pt) > $signed(run.end_pt))
                    run.end_pt = sorted_spans[i].end_pt;
            end else begin
                queue_merge(run, 1'b0, spill_seen);
                run = sorted_spans[i];
            end
        end
        queue_merge(run, 1'b1, spill_seen);
        sets_closed++;
        if (spill_seen)
            sets_spilled++;
        span_count = 0;
        spill_seen = 1'b0;
    endfunction

    // Feed the predictor from every accepted request
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            intervals_taken++;
            absorb_interval(isam_entry_t'(s_tdata), s_tlast);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_merges.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual start %h end %h last %b drop %b",
                         $time, m_tdata[31:0], m_tdata[63:32], m_tlast, m_tuser);
            end else begin
                oldest_merge = expected_merges.pop_front();
                merges_checked++;
                if (m_tdata[31:0] !== oldest_merge.span.start_pt) begin
                    error_count++;
                    $display("%0t: merged_start expected %h actual %h", $time,
                             oldest_merge.span.start_pt, m_tdata[31:0]);
                end
                if (m_tdata[63:32] !== oldest_merge.span.end_pt) begin
                    error_count++;
                    $display("%0t: merged_end expected %h actual %h", $time,
                             oldest_merge.span.end_pt, m_tdata[63:32]);
                end
                if (m_tlast !== oldest_merge.is_last) begin
                    error_count++;
                    $display("%0t: run_last expected %b actual %b", $time,
                             oldest_merge.is_last, m_tlast);
                end
                if (m_tuser !== oldest_merge.dropped) begin
                    error_count++;
                    $display("%0t: dropped_flag expected %b actual %b", $time,
                             oldest_merge.dropped, m_tuser);
                end
            end
        end
    end

    // Back-pressure on the result side: stall about a third of the cycles
    always @(negedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(99) >= 35);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one interval and hold it until the block takes it. Entered and
    // left at a falling edge, so each step sees a single update of s_tvalid.
    task automatic send_interval(input logic [POINT_W-1:0] lo_pt,
                                 input logic [POINT_W-1:0] hi_pt,
                                 input bit closes_set);
        while (!no_gaps && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi_pt, lo_pt};
        s_tlast  <= closes_set;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [POINT_W-1:0] corner_point();
        case ($urandom_range(3))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Mostly short intervals in a narrow window so that sets overlap often;
    // the rest reversed, full range or at the corners of the signed range.
    function automatic isam_entry_t make_interval();
        isam_entry_t span;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            span.start_pt = $urandom_range(200) - 100;
            span.end_pt   = span.start_pt + $urandom_range(24);
        end else if (pick < 70) begin
            span.start_pt = $urandom_range(200) - 100;
            span.end_pt   = span.start_pt - $urandom_range(1, 10);
        end else if (pick < 85) begin
            span.start_pt = $urandom;
            span.end_pt   = $urandom;
        end else begin
            span.start_pt = corner_point();
            span.end_pt   = ($urandom_range(1)) ? corner_point() : $urandom;
        end
        return span;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners of the signed range, reversed intervals, duplicate points
    task automatic test_range_extremes();
        send_interval(MOST_NEG, MOST_POS, 1'b1);
        send_interval(MOST_POS, MOST_NEG, 1'b0);
        send_interval(MOST_NEG, MOST_NEG, 1'b1);
        send_interval(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_interval(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_interval(32'd5, 32'd5, 1'b0);
        send_interval(32'd5, 32'd5, 1'b0);
        send_interval(32'd5, 32'd5, 1'b1);
    endtask

    // Out-of-order arrival, touching, adjacent, nested, tied starts and a
    // reversed interval swallowed by a wider one
    task automatic test_overlap_rules();
        send_interval(32'd10, 32'd20, 1'b0);
        send_interval(32'd1,  32'd3,  1'b0);
        send_interval(32'd3,  32'd5,  1'b0);   // touches the previous one
        send_interval(32'd6,  32'd8,  1'b0);   // one apart, stays separate
        send_interval(32'd15, 32'd30, 1'b0);
        send_interval(32'd12, 32'd14, 1'b0);   // nested
        send_interval(32'd1,  32'd2,  1'b0);   // same start, shorter end
        send_interval(32'd40, 32'd35, 1'b0);   // reversed, on its own
        send_interval(32'd100, 32'd200, 1'b0);
        send_interval(32'd150, 32'd120, 1'b0); // reversed inside a wider one
        send_interval(-32'sd7, -32'sd2, 1'b1);
    endtask

    // Fill the store exactly, then drop the closing request, then drop several
    task automatic test_store_capacity();
        int order [MAX_SPANS];
        int swap_at;
        int held;
        for (int i = 0; i < MAX_SPANS; i++)
            order[i] = i;
        for (int i = MAX_SPANS - 1; i > 0; i--) begin
            swap_at        = $urandom_range(i);
            held           = order[i];
            order[i]       = order[swap_at];
            order[swap_at] = held;
        end
        // Disjoint intervals in shuffled order: a full set of separate results
        for (int i = 0; i < MAX_SPANS; i++)
            send_interval(order[i] * 10, order[i] * 10 + $urandom_range(5),
                          i == MAX_SPANS - 1);
        for (int i = 0; i <= MAX_SPANS; i++)
            send_interval(make_interval().start_pt, make_interval().end_pt,
                          i == MAX_SPANS);
        for (int i = 0; i < MAX_SPANS + 6; i++)
            send_interval(make_interval().start_pt, make_interval().end_pt,
                          i == MAX_SPANS + 5);
    endtask

    // Random sets, mostly small, now and then up to two dozen intervals
    task automatic test_random_sets(input int budget);
        int sent;
        int set_size;
        isam_entry_t span;
        sent = 0;
        while (sent < budget) begin
            set_size = ($urandom_range(9) == 0) ? $urandom_range(9, 24)
                                                : $urandom_range(1, 8);
            for (int k = 0; k < set_size; k++) begin
                span = make_interval();
                send_interval(span.start_pt, span.end_pt, k == set_size - 1);
            end
            sent += set_size;
        end
    endtask

    // Same traffic with no input gaps and the result side always ready
    task automatic test_full_throughput(input int budget);
        no_gaps = 1'b1;
        test_random_sets(budget);
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_range_extremes();
        test_overlap_rules();
        test_store_capacity();
        test_random_sets(150);
        test_full_throughput(60);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain, then watch a while longer for stray results
        while (expected_merges.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Run covered %0d intervals in %0d sets (%0d with dropped intervals),",
                 intervals_taken, sets_closed, sets_spilled);
        $display("and compared %0d merged intervals field by field.", merges_checked);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
